FILE: design/pftm_pkg.sv
package pftm_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_POINTS_DEF = 4096;
    localparam int PHASE_BITS_DEF = 32;
    localparam int TABLE_BITS_DEF = 10;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int RATE_W   = 16;
    localparam int BLEN_W   = 13;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Register reset values.
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd200;
    localparam logic [BLEN_W-1:0] BLEN_RESET = 13'd4096;

    // Two pi in Q4.28, used when the sine table is built.
    localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_COEF_OFFSET    = 3'd0,
        REG_COEF_LINEAR    = 3'd1,
        REG_COEF_QUADRATIC = 3'd2,
        REG_COEF_CUBIC     = 3'd3,
        REG_COEF_QUARTIC   = 3'd4,
        REG_SAMPLE_RATE    = 3'd5,
        REG_BLOCK_LENGTH   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_offset;
        logic signed [COEF_W-1:0] coef_linear;
        logic signed [COEF_W-1:0] coef_quadratic;
        logic signed [COEF_W-1:0] coef_cubic;
        logic signed [COEF_W-1:0] coef_quartic;
        logic [RATE_W-1:0]        sample_rate;
        logic [BLEN_W-1:0]        block_length;
    } cfg_t;

    // One entry of the quarter-wave sine table, Q1.15, from a Taylor series of
    // degree 17 in Q4.28. Only evaluated at elaboration.
    function automatic logic [15:0] sin_entry(input int unsigned j, input int unsigned tbits);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        th   = (64'(j) * TWO_PI_Q28 + (64'd1 << (tbits - 1))) >> tbits;
        th2  = (th * th) >> 28;
        term = th;
        sum  = th;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * th2) >> 28) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + 64'd4096) >> 13;
        return (v > 64'd32767) ? 16'd32767 : v[15:0];
    endfunction

endpackage

FILE: design/pftm_fifo.sv
module pftm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         valid
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/pftm_front.sv
module pftm_front #(
    parameter int MAX_POINTS = pftm_pkg::MAX_POINTS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [pftm_pkg::SAMPLE_W-1:0]  s_sample_re,
    input  logic signed [pftm_pkg::SAMPLE_W-1:0]  s_sample_im,
    input  logic [$clog2(MAX_POINTS + 1)-1:0]     len_eff,
    input  logic                                  q_full,
    output logic                                  push,
    output logic [$clog2(MAX_POINTS) + 2 * pftm_pkg::SAMPLE_W:0] push_data
);
    import pftm_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int LW = $clog2(MAX_POINTS + 1);

    logic [IW-1:0] idx_reg, idx_next;
    logic          last;
    logic [IW-1:0] idx_eff;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // An index at or past the end of the block is held at the last position.
    assign last    = (LW'(idx_reg) >= (len_eff - LW'(1)));
    assign idx_eff = last ? IW'(len_eff - LW'(1)) : idx_reg;

    assign push_data = {last, idx_eff, s_sample_im, s_sample_re};

    always_comb begin
        idx_next = idx_reg;
        if (push) begin
            idx_next = last ? '0 : idx_eff + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

FILE: design/pftm_div.sv
module pftm_div #(
    parameter int NW = 53,
    parameter int DW = 16,
    parameter int RB = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quot,
    output logic          done
);
    localparam int ITERS = (NW + RB - 1) / RB;
    localparam int PW    = ITERS * RB;
    localparam int CW    = $clog2(ITERS + 1);

    logic [PW-1:0] num_reg, num_next;
    logic [PW-1:0] quot_reg, quot_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [PW-1:0] step_num, step_quot;
    logic [DW-1:0] step_rem;

    assign quot = quot_reg[NW-1:0];
    assign done = done_reg;

    // Restoring division, RB quotient bits per cycle.
    always_comb begin
        logic [DW:0]   t;
        logic [DW-1:0] r;
        logic [PW-1:0] n;
        logic [PW-1:0] q;
        r = rem_reg;
        n = num_reg;
        q = quot_reg;
        for (int i = 0; i < RB; i++) begin
            t = {r, n[PW-1]};
            n = {n[PW-2:0], 1'b0};
            if (t >= {1'b0, den_reg}) begin
                t = t - {1'b0, den_reg};
                q = {q[PW-2:0], 1'b1};
            end else begin
                q = {q[PW-2:0], 1'b0};
            end
            r = t[DW-1:0];
        end
        step_num  = n;
        step_quot = q;
        step_rem  = r;
    end

    always_comb begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = PW'(num);
            quot_next = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(ITERS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = step_num;
            quot_next = step_quot;
            rem_next  = step_rem;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

endmodule

FILE: design/pftm_back.sv
module pftm_back #(
    parameter int MAX_POINTS = pftm_pkg::MAX_POINTS_DEF,
    parameter int PHASE_BITS = pftm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = pftm_pkg::TABLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pftm_pkg::cfg_t                        cfg,
    input  logic [$clog2(MAX_POINTS + 1)-1:0]     len_eff,
    input  logic                                  q_valid,
    input  logic [$clog2(MAX_POINTS) + 2 * pftm_pkg::SAMPLE_W:0] q_data,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pftm_pkg::SAMPLE_W-1:0]  m_out_re,
    output logic signed [pftm_pkg::SAMPLE_W-1:0]  m_out_im,
    output logic                                  m_block_end
);
    import pftm_pkg::*;

    localparam int IW      = $clog2(MAX_POINTS);
    localparam int LW      = $clog2(MAX_POINTS + 1);
    localparam int QW      = IW + 2 * SAMPLE_W + 1;
    localparam int DW      = (LW + 1 > RATE_W) ? LW + 1 : RATE_W;
    localparam int AW      = LW + 34;
    localparam int MW      = 36;
    localparam int NW      = (AW > PHASE_BITS + 21) ? AW : PHASE_BITS + 21;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int NS      = 23;

    typedef enum logic [NS-1:0] {
        ST_IDLE = NS'(1) << 0,
        ST_XST  = NS'(1) << 1,
        ST_XDIV = NS'(1) << 2,
        ST_SQ   = NS'(1) << 3,
        ST_SQW  = NS'(1) << 4,
        ST_CU   = NS'(1) << 5,
        ST_QU   = NS'(1) << 6,
        ST_QUW  = NS'(1) << 7,
        ST_LEG  = NS'(1) << 8,
        ST_S0   = NS'(1) << 9,
        ST_S1   = NS'(1) << 10,
        ST_S2   = NS'(1) << 11,
        ST_S3   = NS'(1) << 12,
        ST_S4   = NS'(1) << 13,
        ST_FDIV = NS'(1) << 14,
        ST_IDIV = NS'(1) << 15,
        ST_TAB  = NS'(1) << 16,
        ST_R0   = NS'(1) << 17,
        ST_R1   = NS'(1) << 18,
        ST_R2   = NS'(1) << 19,
        ST_R3   = NS'(1) << 20,
        ST_R4   = NS'(1) << 21,
        ST_DONE = NS'(1) << 22
    } state_t;

    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] re_reg, re_next, im_reg, im_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic                       last_reg, last_next;
    logic                       neg_reg, neg_next;
    logic signed [32:0]         x_reg, x_next, x2_reg, x2_next, x3_reg, x3_next;
    logic signed [32:0]         x4_reg, x4_next;
    logic signed [32:0]         p2_reg, p2_next, p3_reg, p3_next, p4_reg, p4_next;
    logic signed [63:0]         acc_reg, acc_next, prod_reg;
    logic signed [15:0]         sin_reg, sin_next, cos_reg, cos_next, ore_reg, ore_next;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [15:0]         out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic                       block_end_reg, block_end_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_full;

    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quot;
    logic [DW-1:0] div_den;

    logic signed [LW+1:0]  np;
    logic signed [AW-1:0]  xa;
    logic                  xneg;
    logic [AW-1:0]         xmag;
    logic [DW-1:0]         two_len;
    logic [NW-1:0]         xnum;
    logic signed [32:0]    x_div;
    logic [RATE_W-1:0]     rate_eff;
    logic signed [63:0]    f;
    logic                  fneg;
    logic [MW-1:0]         fmag;
    logic [NW-1:0]         fnum;
    logic [PHASE_BITS-1:0] q_lo, inc;
    logic                  out_free;

    logic [15:0]               sin_tab [QUARTER + 1];
    logic [TABLE_BITS-1:0]     kk [2];
    logic signed [15:0]        tab_val [2];

    for (genvar j = 0; j <= QUARTER; j++) begin : g_tab
        assign sin_tab[j] = sin_entry(j, TABLE_BITS);
    end

    pftm_div #(
        .NW (NW),
        .DW (DW),
        .RB (4)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    // Position of the sample within the block: x = (n' * 2^31 + L) / 2L, floored.
    assign np      = (LW + 2)'({idx_reg, 1'b1}) - (LW + 2)'(len_eff);
    assign xa      = (AW'(np) <<< 31) + AW'(len_eff);
    assign xneg    = xa[AW-1];
    assign xmag    = xneg ? AW'(-xa) : AW'(xa);
    assign two_len = DW'({len_eff, 1'b0});
    assign xnum    = NW'(xmag) + (xneg ? NW'(two_len) - NW'(1) : '0);
    assign x_div   = neg_reg ? -33'(div_quot) : 33'(div_quot);

    // Phase increment: |F| scaled into turns over the rate, rounded half away.
    assign rate_eff = (cfg.sample_rate == '0) ? RATE_W'(1) : cfg.sample_rate;
    assign f        = rnd_sh(acc_reg, 22);
    assign fneg     = f[63];
    assign fmag     = MW'(fneg ? -f : f);
    assign fnum     = (NW'(fmag) << (PHASE_BITS - 16)) + NW'(rate_eff >> 1);
    assign q_lo     = div_quot[PHASE_BITS-1:0];
    assign inc      = neg_reg ? -q_lo : q_lo;

    assign prod_full = mul_a * mul_b;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_out_re    = out_re_reg;
    assign m_out_im    = out_im_reg;
    assign m_block_end = block_end_reg;

    // Quarter-wave table lookups for sine and cosine.
    always_comb begin
        logic [1:0]            q;
        logic [TABLE_BITS-3:0] r;
        logic [TABLE_BITS-2:0] addr;
        logic signed [15:0]    v;
        kk[0] = phase_reg[PHASE_BITS-1 -: TABLE_BITS];
        kk[1] = kk[0] + TABLE_BITS'(QUARTER);
        for (int i = 0; i < 2; i++) begin
            q    = kk[i][TABLE_BITS-1:TABLE_BITS-2];
            r    = kk[i][TABLE_BITS-3:0];
            addr = q[0] ? (TABLE_BITS - 1)'(QUARTER) - {1'b0, r} : {1'b0, r};
            v    = sin_tab[addr];
            tab_val[i] = q[1] ? -v : v;
        end
    end

    always_comb begin
        state_next     = state_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        neg_next       = neg_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        x3_next        = x3_reg;
        x4_next        = x4_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        p4_next        = p4_reg;
        acc_next       = acc_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        ore_next       = ore_reg;
        phase_next     = phase_reg;
        out_re_next    = out_re_reg;
        out_im_next    = out_im_reg;
        block_end_next = block_end_reg;
        m_valid_next   = m_valid_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        q_pop          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    re_next    = q_data[SAMPLE_W-1:0];
                    im_next    = q_data[2*SAMPLE_W-1:SAMPLE_W];
                    idx_next   = q_data[2*SAMPLE_W +: IW];
                    last_next  = q_data[QW-1];
                    state_next = ST_XST;
                end
            end
            ST_XST: begin
                div_start  = 1'b1;
                div_num    = xnum;
                div_den    = two_len;
                neg_next   = xneg;
                state_next = ST_XDIV;
            end
            ST_XDIV: begin
                if (div_done) begin
                    x_next     = x_div;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                mul_a      = x_reg;
                mul_b      = x_reg;
                state_next = ST_SQW;
            end
            ST_SQW: begin
                x2_next    = 33'(rnd_sh(prod_reg, 30));
                state_next = ST_CU;
            end
            ST_CU: begin
                mul_a      = x2_reg;
                mul_b      = x_reg;
                state_next = ST_QU;
            end
            ST_QU: begin
                x3_next    = 33'(rnd_sh(prod_reg, 30));
                mul_a      = x2_reg;
                mul_b      = x2_reg;
                state_next = ST_QUW;
            end
            ST_QUW: begin
                x4_next    = 33'(rnd_sh(prod_reg, 30));
                state_next = ST_LEG;
            end
            ST_LEG: begin
                p2_next = 33'(rnd_sh(64'sd3 * 64'(x2_reg) - (64'sd1 <<< 30), 1));
                p3_next = 33'(rnd_sh(64'sd5 * 64'(x3_reg) - 64'sd3 * 64'(x_reg), 1));
                p4_next = 33'(rnd_sh(64'sd35 * 64'(x4_reg) - 64'sd30 * 64'(x2_reg)
                                     + 64'sd3 * (64'sd1 <<< 30), 3));
                state_next = ST_S0;
            end
            ST_S0: begin
                acc_next   = 64'($signed(cfg.coef_offset)) <<< 30;
                mul_a      = 33'($signed(cfg.coef_linear));
                mul_b      = x_reg;
                state_next = ST_S1;
            end
            ST_S1: begin
                acc_next   = acc_reg + prod_reg;
                mul_a      = 33'($signed(cfg.coef_quadratic));
                mul_b      = p2_reg;
                state_next = ST_S2;
            end
            ST_S2: begin
                acc_next   = acc_reg + prod_reg;
                mul_a      = 33'($signed(cfg.coef_cubic));
                mul_b      = p3_reg;
                state_next = ST_S3;
            end
            ST_S3: begin
                acc_next   = acc_reg + prod_reg;
                mul_a      = 33'($signed(cfg.coef_quartic));
                mul_b      = p4_reg;
                state_next = ST_S4;
            end
            ST_S4: begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_FDIV;
            end
            ST_FDIV: begin
                div_start  = 1'b1;
                div_num    = fnum;
                div_den    = DW'(rate_eff);
                neg_next   = fneg;
                state_next = ST_IDIV;
            end
            ST_IDIV: begin
                if (div_done) begin
                    phase_next = phase_reg + inc;
                    state_next = ST_TAB;
                end
            end
            ST_TAB: begin
                sin_next   = tab_val[0];
                cos_next   = tab_val[1];
                state_next = ST_R0;
            end
            ST_R0: begin
                mul_a      = 33'(cos_reg);
                mul_b      = 33'(re_reg);
                state_next = ST_R1;
            end
            ST_R1: begin
                acc_next   = prod_reg;
                mul_a      = 33'(sin_reg);
                mul_b      = 33'(im_reg);
                state_next = ST_R2;
            end
            ST_R2: begin
                acc_next   = acc_reg - prod_reg;
                mul_a      = 33'(cos_reg);
                mul_b      = 33'(im_reg);
                state_next = ST_R3;
            end
            ST_R3: begin
                ore_next   = sat16(rnd_sh(acc_reg, 15));
                acc_next   = prod_reg;
                mul_a      = 33'(sin_reg);
                mul_b      = 33'(re_reg);
                state_next = ST_R4;
            end
            ST_R4: begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_re_next    = ore_reg;
                    out_im_next    = sat16(rnd_sh(acc_reg, 15));
                    block_end_next = last_reg;
                    if (last_reg) begin
                        phase_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        re_reg        <= re_next;
        im_reg        <= im_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        neg_reg       <= neg_next;
        x_reg         <= x_next;
        x2_reg        <= x2_next;
        x3_reg        <= x3_next;
        x4_reg        <= x4_next;
        p2_reg        <= p2_next;
        p3_reg        <= p3_next;
        p4_reg        <= p4_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_full[63:0];
        sin_reg       <= sin_next;
        cos_reg       <= cos_next;
        ore_reg       <= ore_next;
        out_re_reg    <= out_re_next;
        out_im_reg    <= out_im_next;
        block_end_reg <= block_end_next;
    end

`ifndef ASSERT_OFF
    a_phase_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free && last_reg) |=> (phase_reg == '0))
        else $error("phase did not restart after the last sample of a block");

    a_div_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_XDIV || state_reg == ST_IDIV))
        else $error("divider finished outside a wait state");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without passing the final step");
`endif

endmodule

FILE: design/polynomial_frequency_tweak_mixer.sv
// Channel   Ports                                        Direction  Transaction
// input     s_valid s_ready s_sample_re s_sample_im      in         one Q1.15 complex sample
// result    m_valid m_ready m_out_re m_out_im m_block_end out        one rotated sample
// config    psel penable pwrite paddr pwdata prdata       in/out     one register write or read
//
// The back part's shared radix-16 divider runs twice for each sample.
// Reset is synchronous and active low; it restarts the index and the phase at zero.
// A two-entry queue parts the input side from the back part, and an output register
// holds a finished result, so either side may stall without losing a transaction.
module polynomial_frequency_tweak_mixer #(
    parameter int MAX_POINTS = pftm_pkg::MAX_POINTS_DEF,
    parameter int PHASE_BITS = pftm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = pftm_pkg::TABLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pftm_pkg::SAMPLE_W-1:0] s_sample_re,
    input  logic signed [pftm_pkg::SAMPLE_W-1:0] s_sample_im,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pftm_pkg::SAMPLE_W-1:0] m_out_re,
    output logic signed [pftm_pkg::SAMPLE_W-1:0] m_out_im,
    output logic                                 m_block_end,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [4:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import pftm_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int LW = $clog2(MAX_POINTS + 1);
    localparam int QW = IW + 2 * SAMPLE_W + 1;

    cfg_t          cfg_reg, cfg_next;
    reg_idx_t      reg_idx;
    logic          wr_en;
    logic [LW-1:0] len_eff;

    logic          push, q_full, q_valid, q_pop;
    logic [QW-1:0] push_data, q_data;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    // Register writes. An address beyond the last register is ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_COEF_OFFSET:    cfg_next.coef_offset    = pwdata[COEF_W-1:0];
                REG_COEF_LINEAR:    cfg_next.coef_linear    = pwdata[COEF_W-1:0];
                REG_COEF_QUADRATIC: cfg_next.coef_quadratic = pwdata[COEF_W-1:0];
                REG_COEF_CUBIC:     cfg_next.coef_cubic     = pwdata[COEF_W-1:0];
                REG_COEF_QUARTIC:   cfg_next.coef_quartic   = pwdata[COEF_W-1:0];
                REG_SAMPLE_RATE:    cfg_next.sample_rate    = pwdata[RATE_W-1:0];
                REG_BLOCK_LENGTH:   cfg_next.block_length   = pwdata[BLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads return the stored bits, zero extended.
    always_comb begin
        unique case (reg_idx)
            REG_COEF_OFFSET:    prdata = 32'(unsigned'(cfg_reg.coef_offset));
            REG_COEF_LINEAR:    prdata = 32'(unsigned'(cfg_reg.coef_linear));
            REG_COEF_QUADRATIC: prdata = 32'(unsigned'(cfg_reg.coef_quadratic));
            REG_COEF_CUBIC:     prdata = 32'(unsigned'(cfg_reg.coef_cubic));
            REG_COEF_QUARTIC:   prdata = 32'(unsigned'(cfg_reg.coef_quartic));
            REG_SAMPLE_RATE:    prdata = 32'(cfg_reg.sample_rate);
            REG_BLOCK_LENGTH:   prdata = 32'(cfg_reg.block_length);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_offset    <= '0;
            cfg_reg.coef_linear    <= '0;
            cfg_reg.coef_quadratic <= '0;
            cfg_reg.coef_cubic     <= '0;
            cfg_reg.coef_quartic   <= '0;
            cfg_reg.sample_rate    <= RATE_RESET;
            cfg_reg.block_length   <= BLEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // A block length of zero counts as one, and one above the maximum as the maximum.
    always_comb begin
        if (cfg_reg.block_length == '0) begin
            len_eff = LW'(1);
        end else if (32'(cfg_reg.block_length) > MAX_POINTS) begin
            len_eff = LW'(MAX_POINTS);
        end else begin
            len_eff = LW'(cfg_reg.block_length);
        end
    end

    // The front part tracks the sample index and marks the end of each block.
    pftm_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_re (s_sample_re),
        .s_sample_im (s_sample_im),
        .len_eff     (len_eff),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    pftm_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .valid   (q_valid)
    );

    // The back part evaluates the polynomial, advances the phase and rotates the sample.
    pftm_back #(
        .MAX_POINTS (MAX_POINTS),
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .len_eff     (len_eff),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_re    (m_out_re),
        .m_out_im    (m_out_im),
        .m_block_end (m_block_end)
    );

endmodule
